[rtl/core/trd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_pkg
// Shared types and constants for the touchpad report decoder.
// ----------------------------------------------------------------------------
package trd_pkg;

    localparam int SLOTS_DEFAULT     = 5;
    localparam int LONG_DEFAULT      = 32;
    localparam logic [15:0] MAX_Y_RESET = 16'd2047;

    localparam logic [7:0] ID_MULTI  = 8'h5d;
    localparam logic [7:0] ID_SINGLE = 8'h81;
    localparam logic [7:0] ID_FIRST  = 8'h82;
    localparam logic [7:0] ID_SECOND = 8'h83;

    localparam logic [5:0] SHORT_LAST_IDX = 6'd7;
    localparam logic [5:0] COUNT_MAX      = 6'd63;
    localparam logic [5:0] POS_START      = 6'd2;
    localparam logic [5:0] RECORD_BYTES   = 6'd5;

    // record byte slots kept per finger: d0, d1, d2, d4
    localparam logic [1:0] REC_D0 = 2'd0;
    localparam logic [1:0] REC_D1 = 2'd1;
    localparam logic [1:0] REC_D2 = 2'd2;
    localparam logic [1:0] REC_D4 = 2'd3;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_SINGLE,
        KIND_FIRST,
        KIND_SECOND,
        KIND_MULTI
    } frame_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_SLOT,
        ST_MEM_ADDR,
        ST_MEM_DATA,
        ST_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic       accept;
        logic       decode;
        logic       save;
        logic       slot_eval;
        logic       mem_capture;
        logic       pos_adv;
        logic       emit;
        logic       last_slot;
        logic [2:0] slot;
        logic [1:0] k;
    } cmd_t;

    typedef struct packed {
        frame_kind_t kind;
        logic        pair_ok;
        logic        slot_active;
        logic        out_free;
    } status_t;

endpackage

[rtl/core/trd_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_ctrl
// Sequencer: takes report bytes, then walks the finger slots of a frame.
// ----------------------------------------------------------------------------
module trd_ctrl #(
    parameter int FINGER_SLOTS = trd_pkg::SLOTS_DEFAULT
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             last_byte,
    output logic             in_ready,
    input  trd_pkg::status_t status,
    output trd_pkg::cmd_t    cmd
);

    localparam logic [2:0] LAST_SLOT = 3'(FINGER_SLOTS - 1);

    trd_pkg::ctrl_state_t state_reg, state_next;
    logic [2:0] slot_reg, slot_next;
    logic [1:0] k_reg, k_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= trd_pkg::ST_IDLE;
            slot_reg  <= 3'd0;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            slot_reg  <= slot_next;
            k_reg     <= k_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        slot_next  = slot_reg;
        k_next     = k_reg;
        unique case (state_reg)
            trd_pkg::ST_IDLE:
            begin
                if (in_valid && last_byte)
                    state_next = trd_pkg::ST_DECODE;
            end
            trd_pkg::ST_DECODE:
            begin
                slot_next = 3'd0;
                if (status.kind == trd_pkg::KIND_SINGLE ||
                    status.kind == trd_pkg::KIND_MULTI ||
                    (status.kind == trd_pkg::KIND_SECOND && status.pair_ok))
                    state_next = trd_pkg::ST_SLOT;
                else
                    state_next = trd_pkg::ST_IDLE;
            end
            trd_pkg::ST_SLOT:
            begin
                k_next = 2'd0;
                if (status.slot_active && status.kind == trd_pkg::KIND_MULTI)
                    state_next = trd_pkg::ST_MEM_ADDR;
                else
                    state_next = trd_pkg::ST_EMIT;
            end
            trd_pkg::ST_MEM_ADDR:
            begin
                state_next = trd_pkg::ST_MEM_DATA;
            end
            trd_pkg::ST_MEM_DATA:
            begin
                if (k_reg == trd_pkg::REC_D4)
                    state_next = trd_pkg::ST_EMIT;
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = trd_pkg::ST_MEM_ADDR;
                end
            end
            trd_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    if (slot_reg == LAST_SLOT)
                        state_next = trd_pkg::ST_IDLE;
                    else
                    begin
                        slot_next  = slot_reg + 3'd1;
                        state_next = trd_pkg::ST_SLOT;
                    end
                end
            end
            default:
            begin
                state_next = trd_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        cmd           = '0;
        cmd.slot      = slot_reg;
        cmd.k         = k_reg;
        cmd.last_slot = (slot_reg == LAST_SLOT);
        in_ready      = 1'b0;
        unique case (state_reg)
            trd_pkg::ST_IDLE:
            begin
                in_ready   = 1'b1;
                cmd.accept = in_valid;
            end
            trd_pkg::ST_DECODE:
            begin
                cmd.decode = 1'b1;
                cmd.save   = (status.kind == trd_pkg::KIND_FIRST);
            end
            trd_pkg::ST_SLOT:
            begin
                cmd.slot_eval = 1'b1;
            end
            trd_pkg::ST_MEM_ADDR:
            begin
                cmd.k = k_reg;
            end
            trd_pkg::ST_MEM_DATA:
            begin
                cmd.mem_capture = 1'b1;
                cmd.pos_adv     = (k_reg == trd_pkg::REC_D4);
            end
            trd_pkg::ST_EMIT:
            begin
                cmd.emit = status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

[rtl/core/trd_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trd_datapath
// Report buffer, stored first-finger report, record fetch and result register.
// ----------------------------------------------------------------------------
module trd_datapath #(
    parameter int LONG_REPORT_BYTES = trd_pkg::LONG_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  trd_pkg::cmd_t      cmd,
    output trd_pkg::status_t   status,
    input  logic [7:0]         report_byte,
    input  logic               last_byte,
    input  logic               cfg_valid,
    input  logic [15:0]        cfg_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic [2:0]         slot,
    output logic               active,
    output logic [11:0]        pos_x,
    output logic signed [16:0] pos_y,
    output logic [7:0]         pressure,
    output logic               button,
    output logic               last_slot
);

    localparam int AW = $clog2(LONG_REPORT_BYTES);
    localparam logic [5:0] LONG_LAST = 6'(LONG_REPORT_BYTES - 1);
    localparam logic [6:0] LONG_LEN  = 7'(LONG_REPORT_BYTES);
    localparam logic [5:0] LONG_CNT  = 6'(LONG_REPORT_BYTES);

    logic [7:0] mem [LONG_REPORT_BYTES];
    logic [7:0] rdata_reg;
    logic [AW-1:0] rd_addr;
    logic [5:0] rd_sum;

    logic [5:0] count_reg;
    logic [7:0] shadow_reg [8];
    logic [7:0] saved_reg [8];
    trd_pkg::frame_kind_t kind_reg, kind_next;
    logic [15:0] max_y_reg;
    logic [7:0] fbits_reg;
    logic [5:0] pos_reg;
    logic first_reg;
    logic rec_active_reg;
    logic [7:0] rec_reg [4];
    logic [2:0] bit_idx;
    logic room_ok;
    logic slot_active;

    logic out_valid_reg;
    logic [2:0] slot_reg;
    logic active_reg;
    logic [11:0] pos_x_reg;
    logic signed [16:0] pos_y_reg;
    logic [7:0] pressure_reg;
    logic button_reg;
    logic last_slot_reg;

    // byte offset within a record for each fetch step
    always_comb
    begin
        case (cmd.k)
            trd_pkg::REC_D4: rd_sum = pos_reg + 6'd4;
            default:         rd_sum = pos_reg + {4'd0, cmd.k};
        endcase
        rd_addr = rd_sum[AW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && count_reg < LONG_CNT)
            mem[count_reg[AW-1:0]] <= report_byte;
        rdata_reg <= mem[rd_addr];
    end

    // first eight bytes of every report kept at fixed places
    always_ff @(posedge clk)
    begin
        if (cmd.accept && count_reg < 6'd8)
            shadow_reg[count_reg[2:0]] <= report_byte;
    end

    always_comb
    begin
        kind_next = trd_pkg::KIND_NONE;
        if (count_reg == trd_pkg::SHORT_LAST_IDX)
        begin
            if (shadow_reg[0] == trd_pkg::ID_SINGLE)
                kind_next = trd_pkg::KIND_SINGLE;
            else if (shadow_reg[0] == trd_pkg::ID_FIRST)
                kind_next = trd_pkg::KIND_FIRST;
            else if (shadow_reg[0] == trd_pkg::ID_SECOND)
                kind_next = trd_pkg::KIND_SECOND;
        end
        else if (count_reg == LONG_LAST && shadow_reg[0] == trd_pkg::ID_MULTI)
            kind_next = trd_pkg::KIND_MULTI;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 6'd0;
            kind_reg  <= trd_pkg::KIND_NONE;
            max_y_reg <= trd_pkg::MAX_Y_RESET;
            for (int i = 0; i < 8; i++)
                saved_reg[i] <= 8'd0;
        end
        else
        begin
            if (cfg_valid)
                max_y_reg <= cfg_data;
            if (cmd.accept)
            begin
                if (last_byte)
                begin
                    count_reg <= 6'd0;
                    kind_reg  <= kind_next;
                end
                else if (count_reg != trd_pkg::COUNT_MAX)
                    count_reg <= count_reg + 6'd1;
            end
            if (cmd.save)
            begin
                for (int i = 0; i < 8; i++)
                    saved_reg[i] <= shadow_reg[i];
            end
        end
    end

    // finger bit for the current slot, and room left for a multi-finger record
    assign bit_idx     = cmd.slot + 3'd3;
    assign room_ok     = ({1'b0, pos_reg} + {1'b0, trd_pkg::RECORD_BYTES}) <= LONG_LEN;
    assign slot_active = fbits_reg[bit_idx] &&
                         (kind_reg != trd_pkg::KIND_MULTI || room_ok);

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            pos_reg   <= trd_pkg::POS_START;
            first_reg <= 1'b0;
            if (kind_reg == trd_pkg::KIND_MULTI)
                fbits_reg <= shadow_reg[1];
            else if (kind_reg == trd_pkg::KIND_SECOND)
                fbits_reg <= saved_reg[2];
            else
                fbits_reg <= shadow_reg[2];
        end
        if (cmd.slot_eval)
        begin
            rec_active_reg <= slot_active;
            if (slot_active && kind_reg == trd_pkg::KIND_SINGLE)
            begin
                rec_reg[0] <= shadow_reg[3];
                rec_reg[1] <= shadow_reg[4];
                rec_reg[2] <= shadow_reg[5];
                rec_reg[3] <= shadow_reg[7];
            end
            else if (slot_active && kind_reg == trd_pkg::KIND_SECOND)
            begin
                first_reg <= 1'b1;
                if (first_reg)
                begin
                    rec_reg[0] <= shadow_reg[1];
                    rec_reg[1] <= shadow_reg[2];
                    rec_reg[2] <= shadow_reg[3];
                    rec_reg[3] <= shadow_reg[5];
                end
                else
                begin
                    rec_reg[0] <= saved_reg[3];
                    rec_reg[1] <= saved_reg[4];
                    rec_reg[2] <= saved_reg[5];
                    rec_reg[3] <= saved_reg[7];
                end
            end
        end
        if (cmd.mem_capture)
            rec_reg[cmd.k] <= rdata_reg;
        if (cmd.pos_adv)
            pos_reg <= pos_reg + trd_pkg::RECORD_BYTES;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            slot_reg      <= cmd.slot;
            active_reg    <= rec_active_reg;
            button_reg    <= fbits_reg[0];
            last_slot_reg <= cmd.last_slot;
            if (rec_active_reg)
            begin
                pos_x_reg    <= {rec_reg[trd_pkg::REC_D0][7:4], rec_reg[trd_pkg::REC_D1]};
                pos_y_reg    <= $signed({1'b0, max_y_reg} -
                                {6'd0, rec_reg[trd_pkg::REC_D0][2:0],
                                 rec_reg[trd_pkg::REC_D2]});
                pressure_reg <= rec_reg[trd_pkg::REC_D4];
            end
            else
            begin
                pos_x_reg    <= 12'd0;
                pos_y_reg    <= 17'sd0;
                pressure_reg <= 8'd0;
            end
        end
    end

    assign status.kind        = kind_reg;
    assign status.pair_ok     = (saved_reg[0] == trd_pkg::ID_FIRST);
    assign status.slot_active = slot_active;
    assign status.out_free    = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign slot      = slot_reg;
    assign active    = active_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pressure  = pressure_reg;
    assign button    = button_reg;
    assign last_slot = last_slot_reg;

endmodule

[rtl/core/touchpad_report_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touchpad_report_decoder_unit
// Buffers touchpad reports byte by byte and decodes them into slot results.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | report_byte, last_byte
//  out     | output    | out_valid / out_ready| slot, active, pos_x, pos_y,
//          |           |                      | pressure, button, last_slot
//  cfg     | input     | cfg_valid / cfg_ready| cfg_data (max_y)
//
// report bytes are taken while idle; the last byte leads to a decode state
// each slot passes a slot and an emit state; an active multi-finger slot
// also reads its four record bytes one at a time from the report buffer
// bytes are not taken while a frame of five slots is walked
// a waiting result stalls the slot walk; the last one does not block new bytes
// reset clears the byte count and the stored report, and sets max_y to 2047
module touchpad_report_decoder_unit #(
    parameter int FINGER_SLOTS      = trd_pkg::SLOTS_DEFAULT,
    parameter int LONG_REPORT_BYTES = trd_pkg::LONG_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         report_byte,
    input  logic               last_byte,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         slot,
    output logic               active,
    output logic [11:0]        pos_x,
    output logic signed [16:0] pos_y,
    output logic [7:0]         pressure,
    output logic               button,
    output logic               last_slot,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [15:0]        cfg_data
);

    trd_pkg::cmd_t    cmd;
    trd_pkg::status_t status;

    assign cfg_ready = 1'b1;

    trd_ctrl #(
        .FINGER_SLOTS (FINGER_SLOTS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_byte (last_byte),
        .in_ready  (in_ready),
        .status    (status),
        .cmd       (cmd)
    );

    trd_datapath #(
        .LONG_REPORT_BYTES (LONG_REPORT_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .report_byte (report_byte),
        .last_byte   (last_byte),
        .cfg_valid   (cfg_valid),
        .cfg_data    (cfg_data),
        .out_ready   (out_ready),
        .out_valid   (out_valid),
        .slot        (slot),
        .active      (active),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .pressure    (pressure),
        .button      (button),
        .last_slot   (last_slot)
    );

endmodule
